@@ rtl/mfp_pkg.sv @@
// Package for the MIDI file event parser.
// Holds shared types, op codes, event and error codes. No dependencies.
package mfp_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int NOTE_COUNT    = 128;
  localparam int HOLD_DEPTH    = CHANNEL_COUNT * NOTE_COUNT;
  localparam int HOLD_AW       = $clog2(HOLD_DEPTH);
  localparam int TAG_W         = 16;
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = $clog2(Q_DEPTH);

  localparam logic [31:0] MAGIC_MTHD = 32'h4D546864;
  localparam logic [31:0] MAGIC_MTRK = 32'h4D54726B;
  localparam logic [14:0] DIV_MASK   = 15'h7FFF;
  localparam logic [14:0] DIV_DFLT   = 15'd480;
  localparam logic [7:0]  META_TEMPO = 8'h51;
  localparam logic [7:0]  ST_META    = 8'hFF;
  localparam logic [7:0]  ST_SYSEX   = 8'hF0;
  localparam logic [7:0]  ST_SYSEX_E = 8'hF7;
  localparam logic [7:0]  ST_MTC     = 8'hF1;
  localparam logic [7:0]  ST_SPP     = 8'hF2;
  localparam logic [7:0]  ST_SSEL    = 8'hF3;
  localparam logic [7:0]  ST_F4      = 8'hF4;
  localparam logic [7:0]  ST_F6      = 8'hF6;
  localparam logic [3:0]  HI_NOTE_ON  = 4'h9;
  localparam logic [3:0]  HI_NOTE_OFF = 4'h8;
  localparam logic [3:0]  HI_CTRL     = 4'hB;
  localparam logic [3:0]  HI_PROG     = 4'hC;
  localparam logic [3:0]  HI_CPRESS   = 4'hD;

  localparam logic [2:0] EV_DIV      = 3'd0;
  localparam logic [2:0] EV_NOTE_ON  = 3'd1;
  localparam logic [2:0] EV_NOTE_OFF = 3'd2;
  localparam logic [2:0] EV_CTRL     = 3'd3;
  localparam logic [2:0] EV_TEMPO    = 3'd4;
  localparam logic [2:0] EV_TRK_END  = 3'd5;
  localparam logic [2:0] EV_DONE     = 3'd6;
  localparam logic [2:0] EV_ERROR    = 3'd7;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_MTHD   = 2'd1;
  localparam logic [1:0] ERR_TRUNC_HDR = 2'd2;
  localparam logic [1:0] ERR_TRUNC_CHK = 2'd3;

  localparam logic CMD_END = 1'b1;

  localparam logic REG_VZO = 1'b0;
  localparam logic REG_CCC = 1'b1;

  typedef enum logic [4:0] {
    P_MAGIC, P_HLEN, P_HFIELDS, P_HSKIP, P_TAG, P_CLEN, P_CSKIP,
    P_DELTA, P_STATUS, P_META_TYPE, P_META_LEN, P_TEMPO, P_SYSEX_LEN,
    P_TSKIP, P_DATA1, P_DATA2, P_HALT
  } phase_t;

  typedef enum logic [1:0] {OP_EMIT, OP_NOTE, OP_START, OP_END} op_t;

  typedef enum logic [1:0] {B_SWEEP, B_RUN, B_NOTE} bstate_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  kind;
    logic [31:0] tick;
    logic [3:0]  ch;
    logic [6:0]  nn;
    logic [31:0] value;
    logic        dflag;
    logic [15:0] dtr;
    logic [1:0]  err;
    logic        last;
  } ent_t;

  function automatic ent_t mk_ent(op_t op, logic [2:0] kind, logic [31:0] tick,
                                  logic [3:0] ch, logic [6:0] nn, logic [31:0] value,
                                  logic dflag, logic [15:0] dtr, logic [1:0] err);
    ent_t e;
    e.op = op; e.kind = kind; e.tick = tick; e.ch = ch; e.nn = nn;
    e.value = value; e.dflag = dflag; e.dtr = dtr; e.err = err; e.last = 1'b0;
    return e;
  endfunction

  function automatic logic in_track(phase_t p);
    return (p >= P_DELTA) && (p <= P_DATA2);
  endfunction

endpackage

@@ rtl/mfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/mfp_queue.sv @@
// Short op queue between parser front and hold-count back end.
// Takes up to two entries per cycle. Depends on mfp_pkg.
module mfp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push0,
  input  logic          push1,
  input  mfp_pkg::ent_t din0,
  input  mfp_pkg::ent_t din1,
  input  logic          pop,
  output mfp_pkg::ent_t head,
  output logic          q_valid,
  output logic          q_room
);
  import mfp_pkg::*;

  ent_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic [Q_AW-1:0] wp1;

  assign wp1     = wp_r + Q_AW'(1);
  assign head    = mem_r[rp_r];
  assign q_valid = (cnt_r != '0);
  assign q_room  = (cnt_r <= (Q_AW+1)'(Q_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + Q_AW'(push0) + Q_AW'(push1);
    rp_nxt  = rp_r + Q_AW'(pop);
    cnt_nxt = cnt_r + (Q_AW+1)'(push0) + (Q_AW+1)'(push1) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wp_r] <= din0;
    end
    if (push1) begin
      mem_r[wp1] <= din1;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

@@ rtl/mfp_front.sv @@
// Parser front: accepts file bytes, walks header/chunk/track syntax, keeps
// tick and track totals, and pushes up to two ops per byte. Depends on mfp_pkg.
module mfp_front #(
  parameter int TICK_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_command,
  input  logic [7:0]    in_data_byte,
  input  logic          vzo,
  input  logic          ccc,
  input  logic          q_room,
  input  logic          sweep,
  output logic          push0,
  output logic          push1,
  output mfp_pkg::ent_t ent0,
  output mfp_pkg::ent_t ent1
);
  import mfp_pkg::*;

  localparam int SW = ((TICK_WIDTH > 32) ? TICK_WIDTH : 32) + 1;

  phase_t                phase_r, phase_nxt;
  logic [31:0]           fshift_r, fshift_nxt;
  logic [2:0]            fcount_r, fcount_nxt;
  logic [31:0]           chunk_r, chunk_nxt;
  logic [31:0]           skip_r, skip_nxt;
  logic [7:0]            run_r, run_nxt, cur_r, cur_nxt, first_r, first_nxt, meta_r, meta_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt, largest_r, largest_nxt;
  logic [15:0]           ttot_r, ttot_nxt, dtot_r, dtot_nxt;

  logic                  acc, b7;
  logic [7:0]            b, cs;
  logic [31:0]           tv_sh, col_sh, chunk_d, sk_n, add_val;
  logic [2:0]            tv_cnt;
  logic                  tv_done, add_en, fin, fin_ds, done_en, p_v, sk_en, start;
  logic [31:0]           sk_req;
  ent_t                  p_e, f_e, d_e;
  logic [TICK_WIDTH-1:0] tick_base, tick_new;
  logic [SW-1:0]         sum, tk_ext, lg_ext;
  logic [31:0]           tk32, lg32;
  logic [14:0]           div_v;

  assign acc      = in_valid && in_ready;
  assign in_ready = q_room && !sweep;
  assign b        = in_data_byte;
  assign b7       = in_data_byte[7];

  always_comb begin
    phase_nxt = phase_r; fshift_nxt = fshift_r; fcount_nxt = fcount_r;
    chunk_nxt = chunk_r; skip_nxt = skip_r; run_nxt = run_r; cur_nxt = cur_r;
    first_nxt = first_r; meta_nxt = meta_r;
    largest_nxt = largest_r; ttot_nxt = ttot_r; dtot_nxt = dtot_r;
    p_v = 1'b0; p_e = '0; f_e = '0; d_e = '0;
    add_en = 1'b0; add_val = '0; fin = 1'b0; fin_ds = 1'b0; done_en = 1'b0;
    sk_en = 1'b0; sk_req = '0; sk_n = '0; start = 1'b0; cs = cur_r;
    tv_sh   = {fshift_r[24:0], b[6:0]};
    tv_cnt  = fcount_r + 3'd1;
    tv_done = !b7 || (tv_cnt >= 3'd4);
    col_sh  = {fshift_r[23:0], b};
    chunk_d = (chunk_r != '0) ? chunk_r - 32'd1 : chunk_r;
    div_v   = (col_sh[14:0] & DIV_MASK) == '0 ? DIV_DFLT : (col_sh[14:0] & DIV_MASK);
    tick_base = tick_r;
    tick_new  = tick_r;
    sum = '0; tk_ext = '0; lg_ext = '0; tk32 = '0; lg32 = '0;

    if (acc) begin
      if (in_command == CMD_END) begin
        priority if (phase_r == P_MAGIC) begin
          p_v = 1'b1; p_e = mk_ent(OP_EMIT, EV_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_NO_MTHD);
        end else if (phase_r == P_HLEN || phase_r == P_HFIELDS) begin
          p_v = 1'b1; p_e = mk_ent(OP_EMIT, EV_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_TRUNC_HDR);
        end else if (phase_r == P_CLEN) begin
          p_v = 1'b1; p_e = mk_ent(OP_EMIT, EV_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_TRUNC_CHK);
        end else if (phase_r == P_HALT) begin
          p_v = 1'b0;
        end else begin
          if (in_track(phase_r)) begin
            fin = 1'b1; fin_ds = 1'b1;
            add_en = (phase_r == P_DELTA); add_val = fshift_r;
          end
          done_en = 1'b1;
        end
        phase_nxt = P_HALT;
      end else if (in_track(phase_r)) begin
        chunk_nxt = chunk_d;
        unique case (phase_r)
          P_DELTA: begin
            fshift_nxt = tv_sh; fcount_nxt = tv_cnt;
            if (tv_done) begin
              add_en = 1'b1; add_val = tv_sh;
              fshift_nxt = '0; fcount_nxt = '0; phase_nxt = P_STATUS;
            end
          end
          P_STATUS: begin
            if (!b7) begin
              if (run_r == '0) begin
                add_en = 1'b1; add_val = {24'h0, b};
                fshift_nxt = '0; fcount_nxt = '0;
              end else begin
                cs = run_r; cur_nxt = run_r; first_nxt = b;
                if (cs[7:4] == HI_PROG || cs[7:4] == HI_CPRESS) begin
                  phase_nxt = P_DELTA; fshift_nxt = '0; fcount_nxt = '0;
                end else begin
                  phase_nxt = P_DATA2;
                end
              end
            end else begin
              cur_nxt = b;
              run_nxt = (b < ST_SYSEX) ? b : 8'h0;
              priority if (b == ST_META) begin
                phase_nxt = P_META_TYPE;
              end else if (b == ST_SYSEX || b == ST_SYSEX_E) begin
                phase_nxt = P_SYSEX_LEN; fshift_nxt = '0; fcount_nxt = '0;
              end else if (b == ST_MTC || b == ST_SSEL) begin
                sk_en = 1'b1; sk_req = 32'd1;
              end else if (b == ST_SPP) begin
                sk_en = 1'b1; sk_req = 32'd2;
              end else if (b >= ST_F4 && b <= ST_F6) begin
                phase_nxt = P_DELTA; fshift_nxt = '0; fcount_nxt = '0;
              end else begin
                phase_nxt = P_DATA1;
              end
            end
          end
          P_DATA1: begin
            first_nxt = b;
            if (cur_r[7:4] == HI_PROG || cur_r[7:4] == HI_CPRESS) begin
              phase_nxt = P_DELTA; fshift_nxt = '0; fcount_nxt = '0;
            end else begin
              phase_nxt = P_DATA2;
            end
          end
          P_DATA2: begin
            if (cur_r[7:4] == HI_NOTE_ON && (b != '0 || !vzo)) begin
              p_v = 1'b1;
              p_e = mk_ent(OP_NOTE, EV_NOTE_ON, '0, cur_r[3:0], first_r[6:0], '0, 1'b0, '0,
                           ERR_NONE);
            end else if (cur_r[7:4] == HI_NOTE_ON || cur_r[7:4] == HI_NOTE_OFF) begin
              p_v = 1'b1;
              p_e = mk_ent(OP_NOTE, EV_NOTE_OFF, '0, cur_r[3:0], first_r[6:0], '0, 1'b0, '0,
                           ERR_NONE);
            end else if (cur_r[7:4] == HI_CTRL && ccc) begin
              p_v = 1'b1;
              p_e = mk_ent(OP_EMIT, EV_CTRL, '0, cur_r[3:0], first_r[6:0], '0, 1'b0, '0,
                           ERR_NONE);
            end
            phase_nxt = P_DELTA; fshift_nxt = '0; fcount_nxt = '0;
          end
          P_META_TYPE: begin
            meta_nxt = b; fshift_nxt = '0; fcount_nxt = '0; phase_nxt = P_META_LEN;
          end
          P_META_LEN: begin
            fshift_nxt = tv_sh; fcount_nxt = tv_cnt;
            if (tv_done) begin
              if (meta_r == META_TEMPO && tv_sh == 32'd3 && chunk_d >= 32'd3) begin
                fshift_nxt = '0; fcount_nxt = '0; phase_nxt = P_TEMPO;
              end else begin
                sk_en = 1'b1; sk_req = tv_sh;
              end
            end
          end
          P_TEMPO: begin
            fshift_nxt = col_sh; fcount_nxt = tv_cnt;
            if (tv_cnt >= 3'd3) begin
              if (col_sh[23:0] != '0) begin
                p_v = 1'b1;
                p_e = mk_ent(OP_EMIT, EV_TEMPO, '0, '0, '0, {8'h0, col_sh[23:0]}, 1'b0, '0,
                             ERR_NONE);
              end
              phase_nxt = P_DELTA; fshift_nxt = '0; fcount_nxt = '0;
            end
          end
          P_SYSEX_LEN: begin
            fshift_nxt = tv_sh; fcount_nxt = tv_cnt;
            if (tv_done) begin
              sk_en = 1'b1; sk_req = tv_sh;
            end
          end
          P_TSKIP: begin
            skip_nxt = (skip_r != '0) ? skip_r - 32'd1 : skip_r;
            if (skip_nxt == '0) begin
              phase_nxt = P_DELTA; fshift_nxt = '0; fcount_nxt = '0;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
        if (sk_en) begin
          sk_n = (sk_req > chunk_d) ? chunk_d : sk_req;
          if (sk_n == '0) begin
            phase_nxt = P_DELTA; fshift_nxt = '0; fcount_nxt = '0;
          end else begin
            skip_nxt = sk_n; phase_nxt = P_TSKIP;
          end
        end
        if (in_track(phase_nxt) && chunk_d == '0) begin
          fin = 1'b1;
          if (phase_nxt == P_DELTA) begin
            add_en = 1'b1; add_val = fshift_nxt;
          end
        end
      end else begin
        unique case (phase_r)
          P_MAGIC: begin
            fshift_nxt = col_sh; fcount_nxt = tv_cnt;
            if (tv_cnt >= 3'd4) begin
              if (col_sh != MAGIC_MTHD) begin
                p_v = 1'b1;
                p_e = mk_ent(OP_EMIT, EV_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_NO_MTHD);
                phase_nxt = P_HALT;
              end else begin
                fshift_nxt = '0; fcount_nxt = '0; phase_nxt = P_HLEN;
              end
            end
          end
          P_HLEN: begin
            fshift_nxt = col_sh; fcount_nxt = tv_cnt;
            if (tv_cnt >= 3'd4) begin
              skip_nxt = (col_sh > 32'd6) ? col_sh - 32'd6 : '0;
              fshift_nxt = '0; fcount_nxt = '0; phase_nxt = P_HFIELDS;
            end
          end
          P_HFIELDS: begin
            fshift_nxt = col_sh; fcount_nxt = tv_cnt;
            if (tv_cnt >= 3'd6) begin
              p_v = 1'b1;
              p_e = mk_ent(OP_EMIT, EV_DIV, '0, '0, '0, {17'h0, div_v}, 1'b0, '0, ERR_NONE);
              fshift_nxt = '0; fcount_nxt = '0;
              phase_nxt = (skip_r != '0) ? P_HSKIP : P_TAG;
            end
          end
          P_HSKIP, P_CSKIP: begin
            skip_nxt = (skip_r != '0) ? skip_r - 32'd1 : skip_r;
            if (skip_nxt == '0) begin
              fshift_nxt = '0; fcount_nxt = '0; phase_nxt = P_TAG;
            end
          end
          P_TAG: begin
            fshift_nxt = col_sh; fcount_nxt = tv_cnt;
            if (tv_cnt >= 3'd4) begin
              first_nxt = (col_sh == MAGIC_MTRK) ? 8'd1 : 8'd0;
              fshift_nxt = '0; fcount_nxt = '0; phase_nxt = P_CLEN;
            end
          end
          P_CLEN: begin
            fshift_nxt = col_sh; fcount_nxt = tv_cnt;
            if (tv_cnt >= 3'd4) begin
              fshift_nxt = '0; fcount_nxt = '0;
              if (first_r != '0) begin
                start = 1'b1;
                p_v = 1'b1;
                p_e = mk_ent(OP_START, EV_TRK_END, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
                chunk_nxt = col_sh; run_nxt = '0; cur_nxt = '0;
                phase_nxt = P_DELTA;
                fin = (col_sh == '0);
              end else if (col_sh == '0) begin
                phase_nxt = P_TAG;
              end else begin
                skip_nxt = col_sh; phase_nxt = P_CSKIP;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    if (start) begin
      tick_base = '0;
    end
    sum = SW'(tick_base) + SW'(add_en ? add_val : 32'h0);
    tick_new = (sum > SW'({TICK_WIDTH{1'b1}})) ? {TICK_WIDTH{1'b1}} : sum[TICK_WIDTH-1:0];
    tk_ext = SW'(tick_new);
    tk32 = (tk_ext > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tk_ext[31:0];
    p_e.tick = (p_e.op == OP_NOTE || p_e.kind == EV_CTRL || p_e.kind == EV_TEMPO) ?
               tk32 : 32'h0;

    if (fin) begin
      f_e = mk_ent(OP_END, EV_TRK_END, tk32, '0, '0, '0, fin_ds, '0, ERR_NONE);
      if (tick_new > largest_r) begin
        largest_nxt = tick_new;
      end
      if (ttot_r != 16'hFFFF) begin
        ttot_nxt = ttot_r + 16'd1;
      end
      if (fin_ds && dtot_r != 16'hFFFF) begin
        dtot_nxt = dtot_r + 16'd1;
      end
      if (!done_en) begin
        phase_nxt = P_TAG;
      end
      fshift_nxt = '0; fcount_nxt = '0;
    end
    if (done_en) begin
      lg_ext = SW'(largest_nxt);
      lg32 = (lg_ext > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : lg_ext[31:0];
      d_e = mk_ent(OP_EMIT, EV_DONE, lg32, '0, '0, {16'h0, ttot_nxt}, 1'b0, dtot_nxt,
                   ERR_NONE);
    end
    tick_nxt = tick_new;
  end

  always_comb begin
    push0 = 1'b0; push1 = 1'b0; ent0 = p_e; ent1 = f_e;
    if (p_v) begin
      push0 = 1'b1; push1 = fin;
    end else if (fin) begin
      push0 = 1'b1; ent0 = f_e; push1 = done_en; ent1 = d_e;
    end else if (done_en) begin
      push0 = 1'b1; ent0 = d_e;
    end
    ent0.last = !push1;
    ent1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_MAGIC; fshift_r <= '0; fcount_r <= '0; chunk_r <= '0; skip_r <= '0;
      run_r <= '0; cur_r <= '0; first_r <= '0; meta_r <= '0;
      tick_r <= '0; largest_r <= '0; ttot_r <= '0; dtot_r <= '0;
    end else begin
      phase_r <= phase_nxt; fshift_r <= fshift_nxt; fcount_r <= fcount_nxt;
      chunk_r <= chunk_nxt; skip_r <= skip_nxt;
      run_r <= run_nxt; cur_r <= cur_nxt; first_r <= first_nxt; meta_r <= meta_nxt;
      tick_r <= tick_nxt; largest_r <= largest_nxt; ttot_r <= ttot_nxt; dtot_r <= dtot_nxt;
    end
  end
endmodule

@@ rtl/mfp_back.sv @@
// Back end: drains the op queue, keeps per channel/note hold counts in a
// tagged RAM, tracks notes held, and drives the output register.
// Depends on mfp_pkg and mfp_ram.
module mfp_back #(
  parameter int HOLD_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mfp_pkg::ent_t head,
  input  logic          q_valid,
  output logic          pop,
  output logic          sweep,
  output logic          out_valid,
  input  logic          out_ready,
  output mfp_pkg::ent_t out_ent
);
  import mfp_pkg::*;

  localparam int RW = TAG_W + HOLD_WIDTH;

  bstate_t            st_r, st_nxt;
  logic [HOLD_AW-1:0] swc_r, swc_nxt;
  logic [TAG_W-1:0]   gen_r, gen_nxt;
  logic [31:0]        held_r, held_nxt;
  logic               ov_r, ov_nxt;
  ent_t               out_r, out_nxt;

  logic                  out_free, load, re, we;
  logic [HOLD_AW-1:0]    waddr, idx;
  logic [RW-1:0]         wdata, rdata;
  logic [TAG_W-1:0]      tag;
  logic [HOLD_WIDTH-1:0] cnt, cnt_new;
  logic                  wrap;
  ent_t                  lo;

  assign out_free  = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_ent   = out_r;
  assign sweep     = (st_r == B_SWEEP);
  assign idx       = {head.ch, head.nn};
  assign tag       = rdata[RW-1:HOLD_WIDTH];
  assign cnt       = (tag == gen_r) ? rdata[HOLD_WIDTH-1:0] : '0;
  assign wrap      = (gen_r == {TAG_W{1'b1}});

  mfp_ram #(.WIDTH(RW), .DEPTH(HOLD_DEPTH)) u_hold (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(idx), .rdata(rdata)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_SWEEP: begin
        if (swc_r == {HOLD_AW{1'b1}}) begin
          st_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (q_valid && head.op == OP_NOTE) begin
          st_nxt = B_NOTE;
        end else if (q_valid && head.op == OP_START && wrap) begin
          st_nxt = B_SWEEP;
        end
      end
      B_NOTE: begin
        if (out_free || (head.kind == EV_NOTE_OFF && cnt == '0)) begin
          st_nxt = B_RUN;
        end
      end
      default: begin
        st_nxt = B_RUN;
      end
    endcase
  end

  always_comb begin
    swc_nxt = swc_r; gen_nxt = gen_r; held_nxt = held_r;
    pop = 1'b0; re = 1'b0; we = 1'b0; waddr = idx; wdata = '0;
    load = 1'b0; lo = head; cnt_new = cnt;
    unique case (st_r)
      B_SWEEP: begin
        we = 1'b1; waddr = swc_r; swc_nxt = swc_r + HOLD_AW'(1);
      end
      B_RUN: begin
        if (q_valid) begin
          unique case (head.op)
            OP_EMIT: begin
              if (out_free) begin
                load = 1'b1; pop = 1'b1;
              end
            end
            OP_END: begin
              if (out_free) begin
                load = 1'b1; pop = 1'b1; lo.value = held_r; held_nxt = '0;
              end
            end
            OP_START: begin
              pop = 1'b1; held_nxt = '0;
              gen_nxt = wrap ? TAG_W'(1) : gen_r + TAG_W'(1);
              swc_nxt = '0;
            end
            OP_NOTE: begin
              re = 1'b1;
            end
            default: begin
              pop = 1'b0;
            end
          endcase
        end
      end
      B_NOTE: begin
        if (head.kind == EV_NOTE_ON) begin
          if (out_free) begin
            if (cnt != {HOLD_WIDTH{1'b1}}) begin
              cnt_new = cnt + HOLD_WIDTH'(1);
              if (held_r != 32'hFFFF_FFFF) begin
                held_nxt = held_r + 32'd1;
              end
            end
            we = 1'b1; load = 1'b1; pop = 1'b1;
          end
        end else if (cnt == '0) begin
          pop = 1'b1;
        end else if (out_free) begin
          cnt_new = cnt - HOLD_WIDTH'(1);
          if (held_r != '0) begin
            held_nxt = held_r - 32'd1;
          end
          we = 1'b1; load = 1'b1; pop = 1'b1;
        end
        wdata = {gen_r, cnt_new};
      end
      default: begin
        pop = 1'b0;
      end
    endcase

    ov_nxt = ov_r; out_nxt = out_r;
    if (load) begin
      ov_nxt = 1'b1; out_nxt = lo;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      st_r <= B_SWEEP; swc_r <= '0; gen_r <= '0; held_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; swc_r <= swc_nxt; gen_r <= gen_nxt; held_r <= held_nxt; ov_r <= ov_nxt;
    end
  end
endmodule

@@ rtl/midi_file_event_parser.sv @@
// MIDI file event parser top: config registers, parser front, op queue, back end.
// Depends on mfp_pkg, mfp_front, mfp_queue, mfp_back, mfp_ram.
// Results pass the op queue and output register; note ops read, then update hold RAM.
// Throughput: one byte per cycle while the queue has room and no clear pass runs.
// Reset: a clear pass over all 2048 hold RAM entries; no byte is taken meanwhile.
// A generation tag wrap (every 65535 tracks) runs the same pass.
module midi_file_event_parser #(
  parameter int HOLD_WIDTH = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [31:0] out_event_tick,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_note_number,
  output logic [31:0] out_event_value,
  output logic        out_desync_flag,
  output logic [15:0] out_desync_count,
  output logic [1:0]  out_error_code,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import mfp_pkg::*;

  logic vzo_r, ccc_r;
  logic push0, push1, pop, q_valid, q_room, sweep;
  ent_t ent0, ent1, head, out_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vzo_r <= 1'b1;
      ccc_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_VZO) begin
        vzo_r <= cfg_data;
      end
      if (cfg_index == REG_CCC) begin
        ccc_r <= cfg_data;
      end
    end
  end

  mfp_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_data_byte(in_data_byte), .vzo(vzo_r), .ccc(ccc_r),
    .q_room(q_room), .sweep(sweep), .push0(push0), .push1(push1), .ent0(ent0), .ent1(ent1)
  );

  mfp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push0(push0), .push1(push1), .din0(ent0), .din1(ent1),
    .pop(pop), .head(head), .q_valid(q_valid), .q_room(q_room)
  );

  mfp_back #(.HOLD_WIDTH(HOLD_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .q_valid(q_valid), .pop(pop), .sweep(sweep),
    .out_valid(out_valid), .out_ready(out_ready), .out_ent(out_ent)
  );

  assign out_event_kind    = out_ent.kind;
  assign out_event_tick    = out_ent.tick;
  assign out_channel       = out_ent.ch;
  assign out_note_number   = out_ent.nn;
  assign out_event_value   = out_ent.value;
  assign out_desync_flag   = out_ent.dflag;
  assign out_desync_count  = out_ent.dtr;
  assign out_error_code    = out_ent.err;
  assign out_last_result   = out_ent.last;
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for midi_file_event_parser: feeds one MIDI file byte stream with random
// gaps and stalls, predicts every event transaction and checks it. Uses mfp_pkg.
module tb;
  import mfp_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct {
    bit       cmd;
    bit [7:0] b;
  } byte_item_t;

  typedef struct {
    bit [2:0]  kind;
    bit [31:0] tick;
    bit [3:0]  ch;
    bit [6:0]  nn;
    bit [31:0] value;
    bit        dflag;
    bit [15:0] dtr;
    bit [1:0]  err;
    bit        last;
  } midi_ev_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_command;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready;
  logic [2:0]  out_event_kind;
  logic [31:0] out_event_tick, out_event_value;
  logic [3:0]  out_channel;
  logic [6:0]  out_note_number;
  logic        out_desync_flag, out_last_result;
  logic [15:0] out_desync_count;
  logic [1:0]  out_error_code;
  logic        cfg_we, cfg_index, cfg_data;

  midi_file_event_parser u_top (.*);

  // parser model state
  phase_t          ph;
  bit [31:0]       acc, chunk_left, skip_left, held;
  int unsigned     acc_n, gen;
  bit [7:0]        run_st, cur_st, data1, meta_kind;
  longint unsigned tick, peak_tick;
  bit [15:0]       hold_cnt [HOLD_DEPTH];
  bit [15:0]       hold_tag [HOLD_DEPTH];
  bit [15:0]       trk_cnt, desync_cnt;
  bit              vzo, ccc;

  midi_ev_t   step_ev[$];
  midi_ev_t   ev_expected[$];
  byte_item_t pend[$];
  bit [7:0]   body[$];

  int  errs, cyc, gap_left, rstall, hold_left;
  bit  calm, squeeze_req, squeezed, squeeze_on;

  function void emit(bit [2:0] k, longint unsigned t, bit [3:0] c, bit [6:0] n,
                     bit [31:0] v, bit d, bit [15:0] dt, bit [1:0] e);
    midi_ev_t ev;
    if (step_ev.size() >= 3) return;
    ev.kind = k;
    ev.tick = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
    ev.ch = c; ev.nn = n; ev.value = v; ev.dflag = d; ev.dtr = dt; ev.err = e;
    ev.last = 0;
    step_ev.insert(step_ev.size(), ev);
  endfunction

  function bit vlq(bit [7:0] b);
    acc = (acc << 7) | b[6:0];
    acc_n++;
    return !b[7] || acc_n >= 4;
  endfunction

  function void shift_in(bit [7:0] b);
    acc = (acc << 8) | b;
    acc_n++;
  endfunction

  function void clr();
    acc = 0;
    acc_n = 0;
  endfunction

  function void to_delta();
    ph = P_DELTA;
    clr();
  endfunction

  function void skip_n(bit [31:0] n);
    if (n > chunk_left) n = chunk_left;
    if (n == 0) begin
      to_delta();
      return;
    end
    skip_left = n;
    ph = P_TSKIP;
  endfunction

  function void add_ticks(longint unsigned v);
    tick = (v > 64'hFFFFFFFF - tick) ? 64'hFFFFFFFF : tick + v;
  endfunction

  function bit in_trk();
    return ph >= P_DELTA && ph <= P_DATA2;
  endfunction

  function void end_track(bit d);
    if (ph == P_DELTA) add_ticks(acc);
    emit(EV_TRK_END, tick, 0, 0, held, d, 0, ERR_NONE);
    if (tick > peak_tick) peak_tick = tick;
    if (trk_cnt != 16'hFFFF) trk_cnt++;
    if (d && desync_cnt != 16'hFFFF) desync_cnt++;
    held = 0;
    ph = P_TAG;
    clr();
  endfunction

  function void begin_track(bit [31:0] len);
    gen++;
    if (gen > 65535) begin
      gen = 1;
      foreach (hold_tag[i]) hold_tag[i] = 0;
    end
    chunk_left = len;
    tick = 0; run_st = 0; cur_st = 0; held = 0;
    to_delta();
    if (len == 0) end_track(0);
  endfunction

  function void note_pair(bit [7:0] vel);
    bit [3:0]  hi, c;
    bit [6:0]  n;
    int        idx;
    bit [15:0] cnt;
    hi = cur_st[7:4];
    c = cur_st[3:0];
    n = data1[6:0];
    idx = c * NOTE_COUNT + n;
    cnt = (hold_tag[idx] == gen[15:0]) ? hold_cnt[idx] : 16'd0;
    if (hi == HI_NOTE_ON && (vel != 0 || !vzo)) begin
      if (cnt != 16'hFFFF) begin
        cnt++;
        if (held != 32'hFFFFFFFF) held++;
      end
      emit(EV_NOTE_ON, tick, c, n, 0, 0, 0, ERR_NONE);
    end else if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF) begin
      if (cnt == 0) return;
      cnt--;
      if (held != 0) held--;
      emit(EV_NOTE_OFF, tick, c, n, 0, 0, 0, ERR_NONE);
    end else begin
      if (hi == HI_CTRL && ccc) emit(EV_CTRL, tick, c, n, 0, 0, 0, ERR_NONE);
      return;
    end
    hold_cnt[idx] = cnt;
    hold_tag[idx] = gen[15:0];
  endfunction

  function void data_first(bit [7:0] b);
    data1 = b;
    if (cur_st[7:4] == HI_PROG || cur_st[7:4] == HI_CPRESS) to_delta();
    else ph = P_DATA2;
  endfunction

  function void delta_byte(bit [7:0] b);
    if (vlq(b)) begin
      add_ticks(acc);
      clr();
      ph = P_STATUS;
    end
  endfunction

  function void track_byte(bit [7:0] b);
    case (ph)
      P_DELTA: delta_byte(b);
      P_STATUS: begin
        if (!b[7]) begin
          if (run_st == 0) begin
            to_delta();
            delta_byte(b);
          end else begin
            cur_st = run_st;
            data_first(b);
          end
        end else begin
          cur_st = b;
          run_st = (b < ST_SYSEX) ? b : 8'd0;
          if (b == ST_META) ph = P_META_TYPE;
          else if (b == ST_SYSEX || b == ST_SYSEX_E) begin
            ph = P_SYSEX_LEN;
            clr();
          end
          else if (b == ST_MTC || b == ST_SSEL) skip_n(1);
          else if (b == ST_SPP) skip_n(2);
          else if (b >= ST_F4 && b <= ST_F6) to_delta();
          else ph = P_DATA1;
        end
      end
      P_DATA1: data_first(b);
      P_DATA2: begin
        note_pair(b);
        to_delta();
      end
      P_META_TYPE: begin
        meta_kind = b;
        clr();
        ph = P_META_LEN;
      end
      P_META_LEN: begin
        if (vlq(b)) begin
          if (meta_kind == META_TEMPO && acc == 3 && chunk_left >= 3) begin
            clr();
            ph = P_TEMPO;
          end else skip_n(acc);
        end
      end
      P_TEMPO: begin
        shift_in(b);
        if (acc_n >= 3) begin
          if (acc[23:0] != 0) emit(EV_TEMPO, tick, 0, 0, {8'h0, acc[23:0]}, 0, 0, ERR_NONE);
          to_delta();
        end
      end
      P_SYSEX_LEN: if (vlq(b)) skip_n(acc);
      P_TSKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) to_delta();
      end
      default: ;
    endcase
  endfunction

  function void header_byte(bit [7:0] b);
    bit [31:0] v;
    case (ph)
      P_MAGIC: begin
        shift_in(b);
        if (acc_n >= 4) begin
          if (acc != MAGIC_MTHD) begin
            emit(EV_ERROR, 0, 0, 0, 0, 0, 0, ERR_NO_MTHD);
            ph = P_HALT;
          end else begin
            clr();
            ph = P_HLEN;
          end
        end
      end
      P_HLEN: begin
        shift_in(b);
        if (acc_n >= 4) begin
          skip_left = (acc > 6) ? acc - 6 : 32'd0;
          clr();
          ph = P_HFIELDS;
        end
      end
      P_HFIELDS: begin
        shift_in(b);
        if (acc_n >= 6) begin
          v = {17'b0, acc[14:0] & DIV_MASK};
          if (v == 0) v = {17'b0, DIV_DFLT};
          emit(EV_DIV, 0, 0, 0, v, 0, 0, ERR_NONE);
          clr();
          ph = (skip_left > 0) ? P_HSKIP : P_TAG;
        end
      end
      P_HSKIP, P_CSKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) begin
          clr();
          ph = P_TAG;
        end
      end
      P_TAG: begin
        shift_in(b);
        if (acc_n >= 4) begin
          data1 = {7'b0, acc == MAGIC_MTRK};
          clr();
          ph = P_CLEN;
        end
      end
      P_CLEN: begin
        shift_in(b);
        if (acc_n >= 4) begin
          v = acc;
          clr();
          if (data1 != 0) begin_track(v);
          else if (v == 0) ph = P_TAG;
          else begin
            skip_left = v;
            ph = P_CSKIP;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void stream_end();
    case (ph)
      P_MAGIC: emit(EV_ERROR, 0, 0, 0, 0, 0, 0, ERR_NO_MTHD);
      P_HLEN, P_HFIELDS: emit(EV_ERROR, 0, 0, 0, 0, 0, 0, ERR_TRUNC_HDR);
      P_CLEN: emit(EV_ERROR, 0, 0, 0, 0, 0, 0, ERR_TRUNC_CHK);
      P_HALT: return;
      default: begin
        if (in_trk()) end_track(1);
        emit(EV_DONE, peak_tick, 0, 0, {16'b0, trk_cnt}, 0, desync_cnt, ERR_NONE);
      end
    endcase
    ph = P_HALT;
  endfunction

  function void predict_events(bit cmd, bit [7:0] b);
    step_ev.delete();
    if (cmd == CMD_END) stream_end();
    else if (in_trk()) begin
      if (chunk_left > 0) chunk_left--;
      track_byte(b);
      if (in_trk() && chunk_left == 0) end_track(0);
    end else header_byte(b);
    if (step_ev.size() > 0) step_ev[$].last = 1;
    foreach (step_ev[i]) ev_expected.insert(ev_expected.size(), step_ev[i]);
  endfunction

  // stimulus builders
  function void put_byte(bit [7:0] b);
    byte_item_t it;
    it.cmd = 0;
    it.b = b;
    pend.insert(pend.size(), it);
  endfunction

  function void put_word(bit [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
  endfunction

  function void put_body(int v);
    body.insert(body.size(), 8'(v));
  endfunction

  function void add_track(int extra);
    put_word(MAGIC_MTRK);
    put_word(32'(body.size() + extra));
    foreach (body[i]) put_byte(body[i]);
  endfunction

  function bit [3:0] pick_ch();
    return 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3));
  endfunction

  function bit [7:0] pick_note();
    return 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(60, 63));
  endfunction

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function void rand_body(int n_ev);
    bit [7:0] st, rs;
    int       r, k;
    body.delete();
    rs = 0;
    for (int i = 0; i < n_ev; i++) begin
      r = $urandom_range(0, 9);
      k = (r < 6) ? 1 : (r < 8) ? 2 : (r < 9) ? 3 : 4;
      for (int j = 0; j < k - 1; j++) put_body(8'h80 | $urandom_range(0, 127));
      put_body((k == 4) ? $urandom_range(0, 255) : $urandom_range(0, (r < 3) ? 3 : 127));
      r = $urandom_range(0, 99);
      if (r < 66) begin
        if (r < 30) st = {HI_NOTE_ON, pick_ch()};
        else if (r < 48) st = {HI_NOTE_OFF, pick_ch()};
        else if (r < 58) st = {HI_CTRL, pick_ch()};
        else if (r < 62) st = {$urandom_range(0, 1) ? HI_PROG : HI_CPRESS, pick_ch()};
        else st = {$urandom_range(0, 1) ? 4'hE : 4'hA, pick_ch()};
        if (st != rs || $urandom_range(0, 1)) put_body(st);
        rs = st;
        put_body(pick_note());
        if (st[7:4] != HI_PROG && st[7:4] != HI_CPRESS)
          put_body(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127));
      end else if (r < 72) begin
        put_body(ST_META); put_body(META_TEMPO); put_body(3);
        k = $urandom_range(0, 4);
        for (int j = 0; j < 3; j++) put_body(k == 0 ? 0 : $urandom_range(0, 255));
        rs = 0;
      end else if (r < 76) begin
        put_body(ST_META); put_body($urandom_range(0, 127));
        k = $urandom_range(0, 3);
        put_body(k);
        for (int j = 0; j < k; j++) put_body($urandom_range(0, 255));
        rs = 0;
      end else if (r < 80) begin
        put_body($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_E);
        k = $urandom_range(0, 4);
        put_body(k);
        for (int j = 0; j < k; j++) put_body($urandom_range(0, 127));
        rs = 0;
      end else if (r < 84) begin
        k = $urandom_range(0, 2);
        put_body(k == 0 ? ST_MTC : k == 1 ? ST_SSEL : ST_SPP);
        put_body($urandom_range(0, 127));
        if (k == 2) put_body($urandom_range(0, 127));
        rs = 0;
      end else if (r < 87) begin
        put_body($urandom_range(ST_F4, ST_F6));
        rs = 0;
      end else if (r < 90) begin
        put_body($urandom_range(8'hF8, 8'hFE));
        put_body($urandom_range(0, 127));
        put_body($urandom_range(0, 127));
        rs = 0;
      end else if (r < 94) put_body($urandom_range(0, 127));
      else put_body($urandom_range(0, 255));
    end
  endfunction

  task automatic random_tracks(int nbytes);
    int added;
    added = 0;
    while (added < nbytes) begin
      rand_body($urandom_range(4, 18));
      add_track(0);
      added += body.size() + 8;
      if ($urandom_range(0, 9) == 0) begin
        put_word({8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'h4B41});
        put_word(32'd2);
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
        added += 10;
      end
    end
  endtask

  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pend.size() != 0 || in_valid || ev_expected.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(bit v0, bit v1);
    settle();
    cfg_we <= 1; cfg_index <= REG_VZO; cfg_data <= v0;
    @(posedge clk);
    cfg_index <= REG_CCC; cfg_data <= v1;
    @(posedge clk);
    cfg_we <= 0;
    vzo = v0;
    ccc = v1;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    byte_item_t it;
    if (!rst_n) begin
      in_valid <= 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) predict_events(in_command, in_data_byte);
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pend.size() > 0) begin
          it = pend[0];
          pend.delete(0);
          in_valid <= 1;
          in_command <= it.cmd;
          in_data_byte <= it.b;
          gap_left = calm ? 0 : pick_gap();
        end else in_valid <= 0;
      end
    end
  end

  function void check_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endfunction

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      squeeze_on <= 0;
    end else begin
      if (squeeze_req && !squeezed && out_valid) begin
        squeezed = 1;
        hold_left = 400;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      squeeze_on <= (hold_left > 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    midi_ev_t e;
    if (!rst_n) begin
      out_ready <= 0;
      rstall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (ev_expected.size() == 0) begin
          errs++;
          $error("unexpected transaction: kind %0d tick %0d", out_event_kind, out_event_tick);
        end else begin
          e = ev_expected[0];
          ev_expected.delete(0);
          check_field("event_kind", e.kind, out_event_kind);
          check_field("event_tick", e.tick, out_event_tick);
          check_field("channel", e.ch, out_channel);
          check_field("note_number", e.nn, out_note_number);
          check_field("event_value", e.value, out_event_value);
          check_field("desync_flag", e.dflag, out_desync_flag);
          check_field("desync_count", e.dtr, out_desync_count);
          check_field("error_code", e.err, out_error_code);
          check_field("last_result", e.last, out_last_result);
        end
      end
      if (squeeze_on) begin
        out_ready <= 0;
      end else if (rstall > 0) begin
        rstall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!calm) rstall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    byte_item_t fin;
    bit [7:0] dir[] = '{
      8'h00, 8'h3C,                                  // data byte without running status
      8'h90, 8'h3C, 8'h40,
      8'h00, 8'h3C, 8'h00,                           // running status, velocity zero
      8'h00, 8'h80, 8'h3C, 8'h00,                    // unmatched off
      8'h81, 8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
      8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hF8, 8'h01, 8'h02,
      8'h00, 8'hF2, 8'h01, 8'h02,
      8'h00, 8'hF1, 8'h05,
      8'h00, 8'hF4,
      8'h00, 8'hF0, 8'h02, 8'h11, 8'hF7,
      8'h00, 8'hB0, 8'h07, 8'h64,
      8'h00, 8'hC0, 8'h05,
      8'h00, 8'h9F, 8'hC5, 8'h7F                     // note byte with bit 7 set
    };
    rst_n = 0;
    in_valid = 0; in_command = 0; in_data_byte = 0;
    out_ready = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    calm = 0; squeeze_req = 0; squeezed = 0;
    errs = 0; cyc = 0;
    vzo = 1; ccc = 0;
    ph = P_MAGIC;
    acc = 0; acc_n = 0; chunk_left = 0; skip_left = 0;
    run_st = 0; cur_st = 0; data1 = 0; meta_kind = 0;
    tick = 0; peak_tick = 0; gen = 0; held = 0; trk_cnt = 0; desync_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    write_cfg(1, 1);
    put_word(MAGIC_MTHD);
    put_word(32'd8);
    put_byte(8'h00); put_byte(8'h01); put_byte(8'h00); put_byte(8'h03);
    put_byte(8'h80); put_byte(8'h00);                // division 0 -> default
    put_byte(8'hAB); put_byte(8'hCD);                // extra header bytes
    put_word(32'h58465452); put_word(32'd3);
    put_byte(8'h01); put_byte(8'h02); put_byte(8'h03);
    put_word(32'h58465452); put_word(32'd0);
    put_word(MAGIC_MTRK); put_word(32'd0);
    body.delete();
    foreach (dir[i]) put_body(dir[i]);
    for (int i = 0; i < 17; i++) begin                // drive the tick into saturation
      put_body(8'hFF); put_body(8'hFF); put_body(8'hFF);
      put_body(8'h7F); put_body(ST_F4);
    end
    put_body(8'h00); put_body(ST_META); put_body(8'h01);
    put_body(8'h09); put_body(8'hAA);                // meta length clipped to track
    add_track(0);

    write_cfg(0, 0);
    random_tracks(60);
    write_cfg(1, 1);
    squeeze_req = 1;
    random_tracks(70);
    write_cfg(0, 1);
    calm = 1;
    random_tracks(50);
    settle();
    calm = 0;

    rand_body(6);
    put_body(8'h83);                                 // cut-off delta time
    add_track(20);
    fin.cmd = CMD_END;
    fin.b = 8'($urandom_range(0, 255));
    pend.insert(pend.size(), fin);

    settle();
    repeat (20) @(posedge clk);
    if (errs == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
